FILE: hw/rtl/pida_pkg.sv
// ----------------------------------------------------------------------------
// Positional insert/delete array: shared types and codes
// Request codes, status codes, the cell command word and the controller
// state type used by the controller and the row of storage cells.
// ----------------------------------------------------------------------------
package pida_pkg;

  // Width of one stored word and of the slot field broadcast to the cells.
  localparam int DATA_W = 32;
  localparam int SLOT_W = 6;

  // Request codes carried on the input word.
  typedef enum logic [2:0] {
    REQ_INS_START = 3'd0,
    REQ_INS_END   = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_DEL_START = 3'd3,
    REQ_DEL_END   = 3'd4,
    REQ_DEL_POS   = 3'd5,
    REQ_DUMP      = 3'd6
  } req_t;

  // Status codes reported with every result word.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // What each cell does in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  // Command broadcast along the row; each cell compares slot with its index.
  typedef struct packed {
    cell_op_t            op;
    logic [SLOT_W-1:0]   slot;
  } cell_cmd_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

endpackage

FILE: hw/rtl/pida_cell.sv
// ----------------------------------------------------------------------------
// Positional insert/delete array: storage cell
// Holds one entry. On an insert it takes its left neighbour's word or the new
// word; on a delete its right neighbour's word; on a rotate that or the head.
// ----------------------------------------------------------------------------
module pida_cell #(
  parameter int INDEX = 0
) (
  input  logic                                clk,
  input  pida_pkg::cell_cmd_t                 cmd,
  input  logic signed [pida_pkg::DATA_W-1:0]  ins_value,
  input  logic signed [pida_pkg::DATA_W-1:0]  left_data,
  input  logic signed [pida_pkg::DATA_W-1:0]  right_data,
  input  logic signed [pida_pkg::DATA_W-1:0]  head_data,
  output logic signed [pida_pkg::DATA_W-1:0]  data
);

  localparam logic [pida_pkg::SLOT_W-1:0] INDEX_S = pida_pkg::SLOT_W'(INDEX);

  logic signed [pida_pkg::DATA_W-1:0] data_r;
  logic signed [pida_pkg::DATA_W-1:0] data_nxt;

  // Choose this cell's next word from the broadcast command.
  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      pida_pkg::OP_INSERT: begin
        if (INDEX_S > cmd.slot) begin
          data_nxt = left_data;
        end else if (INDEX_S == cmd.slot) begin
          data_nxt = ins_value;
        end
      end
      pida_pkg::OP_DELETE: begin
        if (INDEX_S >= cmd.slot) begin
          data_nxt = right_data;
        end
      end
      pida_pkg::OP_ROTATE: begin
        // The slot names the last stored entry, which receives the head.
        if (INDEX_S < cmd.slot) begin
          data_nxt = right_data;
        end else if (INDEX_S == cmd.slot) begin
          data_nxt = head_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // Entry storage; payload only, so no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

FILE: hw/rtl/pida_ctrl.sv
// ----------------------------------------------------------------------------
// Positional insert/delete array: controller
// Decodes requests, keeps the entry count, drives the cell command and
// registers every result word. A dump rotates the row one step a cycle.
// ----------------------------------------------------------------------------
module pida_ctrl #(
  parameter int CAPACITY = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [2:0]                          req_type,
  input  logic [3:0]                          position,
  input  logic signed [pida_pkg::DATA_W-1:0]  head_data,
  output logic                                busy,
  output pida_pkg::cell_cmd_t                 cmd,
  output logic                                out_strobe,
  output logic [1:0]                          out_status,
  output logic signed [pida_pkg::DATA_W-1:0]  out_element,
  output logic [5:0]                          out_element_index,
  output logic [6:0]                          out_entry_count,
  output logic                                out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  pida_pkg::state_t state_r;
  pida_pkg::state_t state_nxt;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;

  logic                               strobe_r;
  logic                               strobe_nxt;
  logic [1:0]                         status_r;
  logic [1:0]                         status_nxt;
  logic signed [pida_pkg::DATA_W-1:0] element_r;
  logic signed [pida_pkg::DATA_W-1:0] element_nxt;
  logic [5:0]                         index_r;
  logic [5:0]                         index_nxt;
  logic [6:0]                         ecount_r;
  logic [6:0]                         ecount_nxt;
  logic                               last_r;
  logic                               last_nxt;

  logic       accept;
  logic       full;
  logic       empty;
  logic       dump_last;
  logic [6:0] pos_w;
  logic [6:0] cnt_w;

  assign accept    = start && (state_r == pida_pkg::S_IDLE);
  assign full      = (count_r == CAP_C);
  assign empty     = (count_r == '0);
  assign dump_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign pos_w     = {3'b000, position};
  assign cnt_w     = 7'(count_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pida_pkg::S_IDLE: begin
        if (accept && (req_type == pida_pkg::REQ_DUMP) && !empty) begin
          state_nxt = pida_pkg::S_DUMP;
        end
      end
      pida_pkg::S_DUMP: begin
        if (dump_last) begin
          state_nxt = pida_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pida_pkg::S_IDLE;
      end
    endcase
  end

  // Request decode, cell command and result word.
  always_comb begin
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cmd.op      = pida_pkg::OP_HOLD;
    cmd.slot    = '0;
    strobe_nxt  = 1'b0;
    status_nxt  = pida_pkg::ST_OK;
    element_nxt = '0;
    index_nxt   = '0;
    last_nxt    = 1'b1;
    case (state_r)
      pida_pkg::S_IDLE: begin
        if (accept) begin
          strobe_nxt = 1'b1;
          case (req_type)
            pida_pkg::REQ_INS_START,
            pida_pkg::REQ_INS_END,
            pida_pkg::REQ_INS_POS: begin
              if (full) begin
                status_nxt = pida_pkg::ST_FULL;
              end else if (req_type == pida_pkg::REQ_INS_START) begin
                cmd.op    = pida_pkg::OP_INSERT;
                cmd.slot  = '0;
                count_nxt = count_r + CNT_W'(1);
              end else if (req_type == pida_pkg::REQ_INS_END) begin
                cmd.op    = pida_pkg::OP_INSERT;
                cmd.slot  = pida_pkg::SLOT_W'(count_r);
                count_nxt = count_r + CNT_W'(1);
              end else if ((pos_w == 7'd0) || (pos_w > (cnt_w + 7'd1))) begin
                status_nxt = pida_pkg::ST_BADPOS;
              end else begin
                cmd.op    = pida_pkg::OP_INSERT;
                cmd.slot  = {2'b00, position - 4'd1};
                count_nxt = count_r + CNT_W'(1);
              end
            end
            pida_pkg::REQ_DEL_START,
            pida_pkg::REQ_DEL_END,
            pida_pkg::REQ_DEL_POS: begin
              if (empty) begin
                status_nxt = pida_pkg::ST_EMPTY;
              end else if (req_type == pida_pkg::REQ_DEL_START) begin
                cmd.op    = pida_pkg::OP_DELETE;
                cmd.slot  = '0;
                count_nxt = count_r - CNT_W'(1);
              end else if (req_type == pida_pkg::REQ_DEL_END) begin
                // The last entry simply drops out of the count.
                count_nxt = count_r - CNT_W'(1);
              end else if ((pos_w == 7'd0) || (pos_w > cnt_w)) begin
                status_nxt = pida_pkg::ST_BADPOS;
              end else begin
                cmd.op    = pida_pkg::OP_DELETE;
                cmd.slot  = {2'b00, position - 4'd1};
                count_nxt = count_r - CNT_W'(1);
              end
            end
            pida_pkg::REQ_DUMP: begin
              // A non-empty list produces its words from the dump state.
              if (empty) begin
                status_nxt = pida_pkg::ST_EMPTY;
              end else begin
                strobe_nxt = 1'b0;
                idx_nxt    = '0;
              end
            end
            default: begin
              status_nxt = pida_pkg::ST_OK;
            end
          endcase
        end
      end
      pida_pkg::S_DUMP: begin
        // Emit the head, then rotate so that the next entry reaches it.
        strobe_nxt  = 1'b1;
        element_nxt = head_data;
        index_nxt   = 6'(idx_r);
        last_nxt    = dump_last;
        idx_nxt     = idx_r + IDX_W'(1);
        cmd.op      = pida_pkg::OP_ROTATE;
        cmd.slot    = pida_pkg::SLOT_W'(count_r - CNT_W'(1));
      end
      default: begin
        strobe_nxt = 1'b0;
      end
    endcase
    ecount_nxt = 7'(count_nxt);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pida_pkg::S_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    element_r <= element_nxt;
    index_r   <= index_nxt;
    ecount_r  <= ecount_nxt;
    last_r    <= last_nxt;
  end

  assign busy              = (state_r == pida_pkg::S_DUMP);
  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_element       = element_r;
  assign out_element_index = index_r;
  assign out_entry_count   = ecount_r;
  assign out_last          = last_r;

endmodule

FILE: hw/rtl/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// Positional insert/delete array: top level
// An ordered list of signed 32-bit entries held in a row of shifting cells.
//
// A request word (type, value, position) is taken on a clock edge with start
// high and busy low. Every request other than a dump of a non-empty list gives
// one result word on the out_ ports for a single cycle, flagged by out_strobe,
// in the cycle straight after it is taken. Inserts and deletes move every cell
// at once, so a new request can follow in the next cycle. A dump of n entries
// holds busy high while the row rotates one step a cycle through cell 0; from
// the dump state its n result words follow on consecutive cycles through the
// result registers, the final one with out_last set, and the row ends in its
// original order. A dump of an empty list gives one word.
// Reset clears the entry count and the controller; entries are not cleared,
// as only entries below the count are ever read. The receiver cannot stall:
// each result word is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module positional_insert_delete_array #(
  parameter int CAPACITY = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          in_req_type,
  input  logic signed [pida_pkg::DATA_W-1:0]  in_item_value,
  input  logic [3:0]                          in_position,
  output logic                                out_strobe,
  output logic [1:0]                          out_status,
  output logic signed [pida_pkg::DATA_W-1:0]  out_element,
  output logic [5:0]                          out_element_index,
  output logic [6:0]                          out_entry_count,
  output logic                                out_last
);

  pida_pkg::cell_cmd_t                cmd;
  logic signed [pida_pkg::DATA_W-1:0] cell_data [CAPACITY];

  // Request decode, count and result registers.
  pida_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .req_type          (in_req_type),
    .position          (in_position),
    .head_data         (cell_data[0]),
    .busy              (busy),
    .cmd               (cmd),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_element       (out_element),
    .out_element_index (out_element_index),
    .out_entry_count   (out_entry_count),
    .out_last          (out_last)
  );

  // Row of storage cells, each wired to its two neighbours.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [pida_pkg::DATA_W-1:0] left_w;
    logic signed [pida_pkg::DATA_W-1:0] right_w;

    if (i == 0) begin : g_left_end
      assign left_w = cell_data[i];
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_end
      assign right_w = cell_data[i];
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end

    pida_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .ins_value  (in_item_value),
      .left_data  (left_w),
      .right_data (right_w),
      .head_data  (cell_data[0]),
      .data       (cell_data[i])
    );
  end

endmodule

FILE: tb/tb_positional_insert_delete_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench: positional insert/delete array
// Drives request words through the start/busy handshake and keeps its own
// copy of the ordered list and entry count. For every request that is taken
// it works out the result words that should follow and checks each strobed
// result word against them, field by field. A directed part covers the
// empty list, the full list, every request code and the position limits.
// A random part then follows, biased towards well-formed requests.
// ----------------------------------------------------------------------------
module tb_positional_insert_delete_array;

  localparam int CAPACITY = 8;
  localparam int DATA_W = pida_pkg::DATA_W;
  localparam int LIMIT_CYCLES = 100000;
  // The one request code the block does not define; it is answered but ignored.
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  // One expected result word.
  typedef struct {
    pida_pkg::status_t        status;
    logic signed [DATA_W-1:0] element;
    logic [5:0]               index;
    logic [6:0]               count;
    logic                     last;
  } result_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic [2:0]               in_req_type = '0;
  logic signed [DATA_W-1:0] in_item_value = '0;
  logic [3:0]               in_position = '0;
  logic                     busy;
  logic                     out_strobe;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_element;
  logic [5:0]               out_element_index;
  logic [6:0]               out_entry_count;
  logic                     out_last;

  // Words still to come, and the shadow copy of the list.
  result_word_t             results_due[$];
  logic signed [DATA_W-1:0] list_q [CAPACITY];
  int                       list_count = 0;
  int                       errors = 0;
  int                       cycles = 0;
  int                       idle_max = 5;

  positional_insert_delete_array #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_item_value    (in_item_value),
    .in_position      (in_position),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_element      (out_element),
    .out_element_index(out_element_index),
    .out_entry_count  (out_entry_count),
    .out_last         (out_last)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("[positional_insert_delete_array] ERROR");
      $finish;
    end
  end

  // Applies one request to the shadow list and queues the words it gives.
  function automatic void predict_request(input logic [2:0] req,
                                          input logic signed [DATA_W-1:0] val,
                                          input logic [3:0] pos);
    result_word_t word;
    int           slot;
    word.status  = pida_pkg::ST_OK;
    word.element = '0;
    word.index   = '0;
    word.last    = 1'b1;
    slot         = -1;
    case (req)
      pida_pkg::REQ_INS_START, pida_pkg::REQ_INS_END, pida_pkg::REQ_INS_POS: begin
        // Fullness is judged before the position.
        if (list_count >= CAPACITY) word.status = pida_pkg::ST_FULL;
        else if (req == pida_pkg::REQ_INS_START) slot = 0;
        else if (req == pida_pkg::REQ_INS_END) slot = list_count;
        else if (pos == 0 || pos > list_count + 1) word.status = pida_pkg::ST_BADPOS;
        else slot = pos - 1;
        if (slot >= 0) begin
          for (int i = list_count; i > slot; i--) list_q[i] = list_q[i - 1];
          list_q[slot] = val;
          list_count++;
        end
      end
      pida_pkg::REQ_DEL_START, pida_pkg::REQ_DEL_END, pida_pkg::REQ_DEL_POS: begin
        // Emptiness is judged before the position.
        if (list_count == 0) word.status = pida_pkg::ST_EMPTY;
        else if (req == pida_pkg::REQ_DEL_START) slot = 0;
        else if (req == pida_pkg::REQ_DEL_END) slot = list_count - 1;
        else if (pos == 0 || pos > list_count) word.status = pida_pkg::ST_BADPOS;
        else slot = pos - 1;
        if (slot >= 0) begin
          for (int i = slot; i + 1 < list_count; i++) list_q[i] = list_q[i + 1];
          list_count--;
        end
      end
      pida_pkg::REQ_DUMP: begin
        if (list_count == 0) begin
          word.status = pida_pkg::ST_EMPTY;
        end else begin
          // One word per stored entry, the final one marked.
          for (int i = 0; i < list_count; i++) begin
            word.element = list_q[i];
            word.index   = 6'(i);
            word.count   = 7'(list_count);
            word.last    = (i == list_count - 1);
            results_due.push_back(word);
          end
          return;
        end
      end
      default: ;
    endcase
    word.count = 7'(list_count);
    results_due.push_back(word);
  endfunction

  // Random values, with the extremes and small numbers mixed in.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      4: return $signed($urandom_range(0, 20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Sends one request word after a random pause; start is left high so that
  // the next word can follow straight on.
  task automatic issue_request(input logic [2:0] req,
                               input logic signed [DATA_W-1:0] val,
                               input logic [3:0] pos);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_type   <= req;
    in_item_value <= val;
    in_position   <= pos;
    start         <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_request(req, val, pos);
  endtask

  // Holds the sender off until every queued word has arrived.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic check_field(input string name, input logic signed [32:0] want_v,
                             input logic signed [32:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  // Each strobed word is compared with the oldest one still due.
  always @(posedge clk) begin : check_results
    result_word_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (results_due.size() == 0) begin
        $error("result word with none due: status %0d, entry_count %0d",
               out_status, out_entry_count);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("status", 33'(want.status), 33'(out_status));
        check_field("element", 33'(want.element), 33'(out_element));
        check_field("element_index", 33'(want.index), 33'(out_element_index));
        check_field("entry_count", 33'(want.count), 33'(out_entry_count));
        check_field("last", 33'(want.last), 33'(out_last));
      end
    end
  end

  // A dump and every delete on an empty list, and the unused code.
  task automatic test_empty_list();
    issue_request(pida_pkg::REQ_DUMP, 32'sd0, 4'd0);
    issue_request(pida_pkg::REQ_DEL_START, 32'sd0, 4'd0);
    issue_request(pida_pkg::REQ_DEL_END, 32'sd0, 4'd0);
    issue_request(pida_pkg::REQ_DEL_POS, 32'sd0, 4'd0);
    issue_request(REQ_UNUSED, 32'sd5, 4'd3);
  endtask

  // Inserts of each kind, with positions at and beyond the limits.
  task automatic test_insert_requests();
    issue_request(pida_pkg::REQ_INS_POS, 32'sd9, 4'd0);
    issue_request(pida_pkg::REQ_INS_POS, 32'sd9, 4'd2);
    issue_request(pida_pkg::REQ_INS_POS, 32'sh8000_0000, 4'd1);
    issue_request(pida_pkg::REQ_INS_START, 32'sh7fff_ffff, 4'd0);
    issue_request(pida_pkg::REQ_INS_END, -32'sd1, 4'd0);
    issue_request(pida_pkg::REQ_INS_POS, 32'sd0, 4'd3);
    issue_request(pida_pkg::REQ_INS_POS, 32'sh5555_5555, 4'd5);
    issue_request(pida_pkg::REQ_INS_POS, 32'sd7, 4'd15);
  endtask

  // Fill the list, then try every insert on it and dump it whole.
  task automatic test_full_list();
    issue_request(pida_pkg::REQ_INS_START, 32'shaaaa_aaaa, 4'd0);
    issue_request(pida_pkg::REQ_INS_END, 32'sd1, 4'd0);
    issue_request(pida_pkg::REQ_INS_POS, 32'sd12345, 4'd4);
    issue_request(pida_pkg::REQ_INS_START, 32'sd2, 4'd0);
    issue_request(pida_pkg::REQ_INS_END, 32'sd3, 4'd0);
    issue_request(pida_pkg::REQ_INS_POS, 32'sd4, 4'd0);
    issue_request(pida_pkg::REQ_DUMP, 32'sd0, 4'd0);
  endtask

  // Deletes of each kind, with positions at and beyond the limits.
  task automatic test_delete_requests();
    issue_request(pida_pkg::REQ_DEL_POS, 32'sd0, 4'd0);
    issue_request(pida_pkg::REQ_DEL_POS, 32'sd0, 4'd9);
    issue_request(pida_pkg::REQ_DEL_POS, 32'sd0, 4'd8);
    issue_request(pida_pkg::REQ_DEL_POS, 32'sd0, 4'd3);
    issue_request(pida_pkg::REQ_DEL_START, 32'sd0, 4'd0);
    issue_request(pida_pkg::REQ_DEL_END, 32'sd0, 4'd0);
    issue_request(pida_pkg::REQ_DUMP, 32'sd0, 4'd0);
  endtask

  // Random traffic: mostly valid requests whose mix keeps the list moving
  // between empty and full, with some noise and frequent dumps.
  task automatic test_random_traffic(input int n_items);
    int         sent;
    int         roll;
    int         ins_share;
    bit         paused;
    logic [2:0] req;
    logic [3:0] pos;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (sent % 40 == 0) idle_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      if (!paused && sent >= n_items / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
      roll      = $urandom_range(0, 99);
      ins_share = (list_count <= 2) ? 70 : ((list_count >= CAPACITY - 1) ? 30 : 50);
      if (roll < 8) begin
        req = 3'($urandom_range(0, 7));
        pos = 4'($urandom_range(0, 15));
      end else if (roll < 20) begin
        req = pida_pkg::REQ_DUMP;
        pos = 4'($urandom_range(0, 15));
      end else if ($urandom_range(0, 99) < ins_share) begin
        case ($urandom_range(0, 2))
          0: req = pida_pkg::REQ_INS_START;
          1: req = pida_pkg::REQ_INS_END;
          default: req = pida_pkg::REQ_INS_POS;
        endcase
        if ($urandom_range(0, 9) == 0) pos = 4'($urandom_range(0, 15));
        else pos = 4'($urandom_range(1, list_count + 1));
      end else begin
        case ($urandom_range(0, 2))
          0: req = pida_pkg::REQ_DEL_START;
          1: req = pida_pkg::REQ_DEL_END;
          default: req = pida_pkg::REQ_DEL_POS;
        endcase
        if (list_count == 0 || $urandom_range(0, 9) == 0) pos = 4'($urandom_range(0, 15));
        else pos = 4'($urandom_range(1, list_count));
      end
      issue_request(req, pick_value(), pos);
      if (req != REQ_UNUSED) sent++;
    end
  endtask

  initial begin : run_tests
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_insert_requests();
    test_full_list();
    test_delete_requests();
    test_random_traffic(200);
    wait_for_results();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("[positional_insert_delete_array] OK");
    end else begin
      $display("[positional_insert_delete_array] ERROR");
    end
    $finish;
  end

endmodule
